/* design/lcac_pkg.sv */
// Package for the LRU cache access-cost block: widths, cost codes, key folding.
// Used by lcac_store and lru_cache_access_cost; no dependencies.
package lcac_pkg;

    localparam int DEF_WAYS      = 32;
    localparam int DEF_KEY_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int CFG_W         = 6;
    localparam int COST_W        = 3;
    localparam int TOTAL_W       = 32;
    localparam int OUT_W         = 40;

    localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
    localparam logic [COST_W-1:0] MISS_COST = 3'd5;

    typedef struct packed {
        logic cfg_we;
        logic access;
    } t_ctl;

    // Fold ASCII capitals to lower case, byte by byte.
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic [7:0]       ch;
        res = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            ch = raw[8*b +: 8];
            if (ch >= 8'h41 && ch <= 8'h5A) begin
                ch = ch + 8'h20;
            end
            res[8*b +: 8] = ch;
        end
        return res;
    endfunction

endpackage

/* design/lcac_store.sv */
// Tag store, valid bits and recency ranks of the fully associative cache.
// Parallel compare, LRU rank update and eviction; uses lcac_pkg.
module lcac_store #(
    parameter int WAYS      = lcac_pkg::DEF_WAYS,
    parameter int KEY_BYTES = lcac_pkg::DEF_KEY_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcac_pkg::t_ctl             i_ctl,
    input  logic [lcac_pkg::CFG_W-1:0] i_cfg_size,
    input  logic [8*KEY_BYTES-1:0]     i_key,
    output logic                       o_hit
);
    localparam int KW = 8 * KEY_BYTES;
    localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = RW + 1;
    localparam int SW = lcac_pkg::CFG_W + 1;

    logic [KW-1:0]              r_key [WAYS];
    logic [WAYS-1:0]            r_vld, n_vld;
    logic [RW-1:0]              r_rank [WAYS];
    logic [RW-1:0]              n_rank [WAYS];
    logic [lcac_pkg::CFG_W-1:0] r_size;

    logic [CW-1:0]   lim, cfg_lim;
    logic [WAYS-1:0] match, keep;
    logic [RW-1:0]   hit_idx, free_idx, hit_rank;
    logic [CW-1:0]   inc [WAYS];
    logic            key_we;

    always_comb begin
        lim = ({1'b0, r_size} >= SW'(WAYS)) ? CW'(WAYS) : CW'(r_size);
        cfg_lim = ({1'b0, i_cfg_size} >= SW'(WAYS)) ? CW'(WAYS) : CW'(i_cfg_size);
        hit_idx  = '0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = r_vld[w] && (r_key[w] == i_key);
            inc[w]   = {1'b0, r_rank[w]} + CW'(1);
            keep[w]  = r_vld[w] && (inc[w] < lim);
            if (match[w]) begin
                hit_idx = RW'(w);
            end
            if (!keep[w]) begin
                free_idx = RW'(w);
            end
        end
        o_hit    = |match;
        hit_rank = r_rank[hit_idx];
    end

    always_comb begin
        n_vld  = r_vld;
        n_rank = r_rank;
        key_we = 1'b0;
        if (i_ctl.cfg_we) begin
            for (int w = 0; w < WAYS; w++) begin
                if (r_vld[w] && ({1'b0, r_rank[w]} >= cfg_lim)) begin
                    n_vld[w]  = 1'b0;
                    n_rank[w] = '0;
                end
            end
        end else if (i_ctl.access) begin
            if (o_hit) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (r_vld[w] && (r_rank[w] < hit_rank)) begin
                        n_rank[w] = inc[w][RW-1:0];
                    end
                end
                n_rank[hit_idx] = '0;
            end else if (lim != '0) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (keep[w]) begin
                        n_rank[w] = inc[w][RW-1:0];
                    end else begin
                        n_vld[w]  = 1'b0;
                        n_rank[w] = '0;
                    end
                end
                n_vld[free_idx]  = 1'b1;
                n_rank[free_idx] = '0;
                key_we           = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_size <= '0;
            for (int w = 0; w < WAYS; w++) begin
                r_rank[w] <= '0;
            end
        end else begin
            r_vld  <= n_vld;
            r_rank <= n_rank;
            if (i_ctl.cfg_we) begin
                r_size <= i_cfg_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[free_idx] <= i_key;
        end
    end

endmodule

/* design/lru_cache_access_cost.sv */
// Top level of the LRU cache access-cost block: stream ports, input and result
// registers, running total. Uses lcac_pkg and lcac_store.
//
// Usage:
//   Input stream s_axis carries one access key per item (8 bytes, first byte
//   in tdata[7:0]); capitals are folded to lower case and the key is held in
//   an input register. From there it is compared against all ways at
//   once, the LRU ranks are updated, and the result is loaded into the output
//   register on m_axis: hit, cost (1 or 5) and the saturating running total.
//   One item per cycle is sustained while m_axis does not stall, with the
//   lookup and rank update done between the input and output registers.
//   When m_axis stalls, the result is held; one more item may enter the input
//   register, then s_axis_tready drops until the result is taken.
//   Reset empties the cache, clears the total and sets the size to 0 (every
//   access misses until a size is written). i_cfg_we/i_cfg_wdata write the
//   size; lowering it evicts the least recent entries beyond the new size.
//   Write the size only while no item is in flight.
module lru_cache_access_cost #(
    parameter int WAYS      = lcac_pkg::DEF_WAYS,
    parameter int KEY_BYTES = lcac_pkg::DEF_KEY_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcac_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lcac_pkg::KEY_W-1:0]    s_axis_tdata,  // access_key[63:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lcac_pkg::OUT_W-1:0]    m_axis_tdata   // hit, access_cost, total_cost, pad
);
    localparam int KW = 8 * KEY_BYTES;

    logic                           r_in_vld;
    logic [KW-1:0]                  r_in_key;
    logic                           r_out_vld;
    logic                           r_out_hit;
    logic [lcac_pkg::COST_W-1:0]    r_out_cost;
    logic [lcac_pkg::TOTAL_W-1:0]   r_total, n_total;

    logic                           advance, access, hit;
    logic [lcac_pkg::KEY_W-1:0]     folded;
    logic [lcac_pkg::COST_W-1:0]    cost;
    logic [lcac_pkg::TOTAL_W:0]     sum;
    lcac_pkg::t_ctl                 ctl;

    assign advance       = !r_out_vld || m_axis_tready;
    assign access        = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign folded        = lcac_pkg::fold_key(s_axis_tdata);

    assign ctl.cfg_we = i_cfg_we;
    assign ctl.access = access;

    lcac_store #(
        .WAYS      (WAYS),
        .KEY_BYTES (KEY_BYTES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cfg_size (i_cfg_wdata),
        .i_key      (r_in_key),
        .o_hit      (hit)
    );

    always_comb begin
        cost    = hit ? lcac_pkg::HIT_COST : lcac_pkg::MISS_COST;
        sum     = {1'b0, r_total} + (lcac_pkg::TOTAL_W + 1)'(cost);
        n_total = sum[lcac_pkg::TOTAL_W] ? '1 : sum[lcac_pkg::TOTAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_total   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (access) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_key <= folded[KW-1:0];
        end
        if (access) begin
            r_out_hit  <= hit;
            r_out_cost <= cost;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(lcac_pkg::OUT_W - lcac_pkg::TOTAL_W - lcac_pkg::COST_W - 1){1'b0}},
                            r_total, r_out_cost, r_out_hit};

endmodule

/* tb/tb.sv */
// Testbench for lru_cache_access_cost: streams access keys, predicts hit, cost and
// running total with its own LRU cache copy, and checks every result item.
// Depends on lcac_pkg and the lru_cache_access_cost RTL only.
`timescale 1ns / 100ps

module tb;
    import lcac_pkg::*;

    localparam int WAYS   = DEF_WAYS;
    localparam int POOL_N = 48;

    typedef struct packed {
        logic                hit;
        logic [COST_W-1:0]   cost;
        logic [TOTAL_W-1:0]  total;
    } access_result_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [KEY_W-1:0]   s_axis_tdata  = '0;  // access_key[63:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;        // hit, access_cost[2:0], total_cost[31:0], pad

    // cache shadow
    logic [KEY_W-1:0]   way_key   [WAYS];
    logic               way_valid [WAYS];
    int                 way_rank  [WAYS];
    int                 occupancy = 0;
    int                 size_cfg  = 0;
    logic [TOTAL_W-1:0] run_total = '0;

    logic [KEY_W-1:0]   pending_keys[$];
    access_result_t     expected_results[$];
    logic [KEY_W-1:0]   key_pool[POOL_N];
    logic               in_taken = 1'b0;
    int                 src_idle_pct  = 0;
    int                 snk_stall_pct = 0;
    int                 mismatches    = 0;

    lru_cache_access_cost u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [KEY_W-1:0] lower_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic [7:0]       ch;
        for (int b = 0; b < KEY_W / 8; b++) begin
            ch = raw[8*b +: 8];
            k[8*b +: 8] = (ch >= "A" && ch <= "Z") ? ch + 8'h20 : ch;
        end
        return k;
    endfunction

    function automatic int size_limit();
        return (size_cfg > WAYS) ? WAYS : size_cfg;
    endfunction

    function automatic void evict_beyond_size();
        int lim;
        lim = size_limit();
        for (int w = 0; w < WAYS; w++) begin
            if (way_valid[w] && way_rank[w] >= lim) begin
                way_valid[w] = 1'b0;
                way_rank[w]  = 0;
                if (occupancy > 0) begin
                    occupancy--;
                end
            end
        end
    endfunction

    function automatic access_result_t predict_access(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] key;
        int               found;
        int               r;
        logic             placed;
        access_result_t   res;
        key   = lower_key(raw);
        found = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (found < 0 && way_valid[w] && way_key[w] == key) begin
                found = w;
            end
        end
        if (found >= 0) begin
            r = way_rank[found];
            for (int w = 0; w < WAYS; w++) begin
                if (way_valid[w] && way_rank[w] < r) begin
                    way_rank[w]++;
                end
            end
            way_rank[found] = 0;
            res.cost = HIT_COST;
        end else begin
            res.cost = MISS_COST;
            if (size_limit() > 0) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (way_valid[w]) begin
                        way_rank[w]++;
                    end
                end
                evict_beyond_size();
                placed = 1'b0;
                for (int w = 0; w < WAYS; w++) begin
                    if (!placed && !way_valid[w]) begin
                        way_valid[w] = 1'b1;
                        way_key[w]   = key;
                        way_rank[w]  = 0;
                        occupancy++;
                        placed = 1'b1;
                    end
                end
            end
        end
        // saturating total
        if (run_total > 32'hFFFF_FFFF - TOTAL_W'(res.cost)) begin
            run_total = 32'hFFFF_FFFF;
        end else begin
            run_total = run_total + TOTAL_W'(res.cost);
        end
        res.hit   = (found >= 0);
        res.total = run_total;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] text_key(input string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < KEY_W / 8; i++) begin
            k[8*i +: 8] = s[i];
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] mix_case(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic [7:0]       ch;
        res = k;
        for (int b = 0; b < KEY_W / 8; b++) begin
            ch = k[8*b +: 8];
            if (ch >= "a" && ch <= "z" && $urandom_range(1) == 1) begin
                res[8*b +: 8] = ch - 8'h20;
            end
        end
        return res;
    endfunction

    // driver and ready generator
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_keys.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_keys[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: predict on accept, compare on result
    always @(posedge i_clk) begin
        access_result_t want;
        access_result_t got;
        if (i_rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                void'(pending_keys.pop_front());
                expected_results.push_back(predict_access(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit   = m_axis_tdata[0];
                got.cost  = m_axis_tdata[3:1];
                got.total = m_axis_tdata[35:4];
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.cost !== want.cost) begin
                        $error("access_cost: expected %0d, actual %0d", want.cost, got.cost);
                        mismatches++;
                    end
                    if (got.total !== want.total) begin
                        $error("total_cost: expected %0d, actual %0d", want.total, got.total);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_keys.size() != 0 || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_size(input int value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        size_cfg = value;
        evict_beyond_size();
    endtask

    initial begin
        int               len;
        int               win;
        int               r;
        int               sizes[8];
        logic [7:0]       ch;
        logic [KEY_W-1:0] k;
        sizes = '{32, 63, 0, 5, 1, 33, 17, 2};
        for (int w = 0; w < WAYS; w++) begin
            way_key[w]   = '0;
            way_valid[w] = 1'b0;
            way_rank[w]  = 0;
        end
        for (int i = 0; i < POOL_N; i++) begin
            len = $urandom_range(8);
            k   = '0;
            for (int b = 0; b < len; b++) begin
                if ($urandom_range(9) < 7) begin
                    ch = 8'h61 + 8'($urandom_range(25));
                end else begin
                    ch = 8'($urandom_range(255));
                end
                k[8*b +: 8] = ch;
            end
            key_pool[i] = k;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // size 0 after reset: everything misses
        pending_keys.push_back('0);
        pending_keys.push_back('1);
        pending_keys.push_back(text_key("ABC"));
        pending_keys.push_back(text_key("abc"));
        // single entry
        write_size(1);
        pending_keys.push_back(text_key("Abc"));
        pending_keys.push_back(text_key("abc"));
        pending_keys.push_back(text_key("ZZ"));
        pending_keys.push_back(text_key("abc"));
        // LRU order and case-fold boundaries
        write_size(4);
        pending_keys.push_back(text_key("a"));
        pending_keys.push_back(text_key("b"));
        pending_keys.push_back(text_key("c"));
        pending_keys.push_back(text_key("d"));
        pending_keys.push_back(text_key("A"));
        pending_keys.push_back(text_key("e"));
        pending_keys.push_back(text_key("b"));
        pending_keys.push_back(64'h617A_415A_405B_607B);
        pending_keys.push_back(64'h617A_617A_405B_607B);
        // shrink with a full cache
        write_size(2);
        pending_keys.push_back(text_key("E"));
        pending_keys.push_back(text_key("a"));
        pending_keys.push_back(text_key("d"));
        // oversize register value clamps to the way count
        write_size(63);
        pending_keys.push_back(text_key("a"));
        pending_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_keys.push_back(64'h0000_0000_0000_0000);

        for (int ph = 0; ph < 8; ph++) begin
            write_size(sizes[ph]);
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 23; snk_stall_pct = 23; end
            endcase
            win = ((sizes[ph] > WAYS) ? WAYS : sizes[ph]) + 6;
            if (win > POOL_N) begin
                win = POOL_N;
            end
            for (int i = 0; i < 105; i++) begin
                r = $urandom_range(99);
                if (r < 12) begin
                    k = {$urandom, $urandom};
                end else if (r < 90) begin
                    k = mix_case(key_pool[$urandom_range(win - 1)]);
                end else begin
                    k = mix_case(key_pool[$urandom_range(POOL_N - 1)]);
                end
                pending_keys.push_back(k);
                // short bursts, then let the stream run dry now and then
                if ($urandom_range(99) < 3) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/lcac_pkg.sv
design/lcac_store.sv
design/lru_cache_access_cost.sv
tb/tb.sv
